// File: design/zph_pkg.sv
// ----------------------------------------------------------------------------
// zph_pkg
// constants, item codes and the tempering function of the zobrist hash block
// ----------------------------------------------------------------------------
package zph_pkg;

	localparam int SQUARES_DEF     = 64;
	localparam int PIECE_KINDS_DEF = 7;

	localparam int TW_N   = 312;
	localparam int TW_M   = 156;
	localparam int TW_AW  = 9;

	localparam logic [63:0] TW_MATRIX = 64'hB502_6F5A_A966_19E9;
	localparam logic [63:0] TW_UPPER  = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] TW_LOWER  = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] SEED_MULT = 64'h5851_F42D_4C95_7F2D;
	localparam logic [63:0] SEED_RST  = 64'd1337;

	localparam int EP_KEYS     = 8;
	localparam int CASTLE_KEYS = 16;
	localparam int EXTRA_KEYS  = EP_KEYS + CASTLE_KEYS + 1;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_PIECE  = 2'd1,
		KIND_FINISH = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	function automatic logic [63:0] temper(input logic [63:0] v);
		logic [63:0] x;
		x = v;
		x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
		x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
		x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
		x = x ^ (x >> 43);
		return x;
	endfunction

endpackage

// File: design/zph_ram.sv
// ----------------------------------------------------------------------------
// zph_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module zph_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/zobrist_position_hash_top.sv
// ----------------------------------------------------------------------------
// zobrist_position_hash_top
// zobrist hash of a chess position over a key table filled by an mt19937-64
// ----------------------------------------------------------------------------
// After reset or a seed write the block seeds the generator (M0, M1, M2
// and SWR per state word) and fills the key table (RDA, RDB, RDC, TWIST
// and STORE per key); s_axis_tready stays low until then.
// Afterwards it takes one item per cycle: a piece item is one key ram read
// and one xor into the accumulator in the next cycle, a finish item loads the
// output register. Only a finish waiting on a held output register stalls
// the input side.
module zobrist_position_hash_top #(
	parameter int SQUARES     = zph_pkg::SQUARES_DEF,
	parameter int PIECE_KINDS = zph_pkg::PIECE_KINDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data,       // key_seed
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // piece_color, piece_type, square,
	                                    // castle_rights, ep_valid, ep_file,
	                                    // black_to_move, zero fill
	input  logic [1:0]  s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // position_hash
);

	import zph_pkg::*;

	localparam int PIECE_KEYS = 2 * PIECE_KINDS * SQUARES;
	localparam int KEY_COUNT  = PIECE_KEYS + EXTRA_KEYS;
	localparam int PIDX_W     = $clog2(PIECE_KEYS);
	localparam int FC_W       = $clog2(KEY_COUNT + 1);

	typedef enum logic [10:0] {
		F_SEED0 = 11'b000_0000_0001,
		F_M0    = 11'b000_0000_0010,
		F_M1    = 11'b000_0000_0100,
		F_M2    = 11'b000_0000_1000,
		F_SWR   = 11'b000_0001_0000,
		F_RDA   = 11'b000_0010_0000,
		F_RDB   = 11'b000_0100_0000,
		F_RDC   = 11'b000_1000_0000,
		F_TWIST = 11'b001_0000_0000,
		F_STORE = 11'b010_0000_0000,
		F_DONE  = 11'b100_0000_0000
	} fill_t;

	fill_t              fsm_q;
	logic [63:0]        seed_q;
	logic [63:0]        p_q;
	logic [63:0]        lo_q;
	logic [31:0]        cr1_q;
	logic [31:0]        cr2_q;
	logic [TW_AW-1:0]   si_q;
	logic [TW_AW-1:0]   ti_q;
	logic [FC_W-1:0]    fc_q;
	logic [63:0]        a_q;
	logic [63:0]        b_q;
	logic [63:0]        x_q;
	logic [63:0]        ep_key_q [EP_KEYS];
	logic [63:0]        castle_key_q [CASTLE_KEYS];
	logic [63:0]        side_key_q;

	logic [63:0]        t_mix;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic [63:0]        seed_val;
	logic [63:0]        y_mix;
	logic [63:0]        twist_val;
	logic [63:0]        key_val;
	logic [TW_AW-1:0]   ti_next;
	logic [TW_AW-1:0]   ti_mid;
	logic [FC_W-1:0]    fc_off;
	logic [FC_W-1:0]    fc_off2;

	logic               st_we;
	logic [TW_AW-1:0]   st_waddr;
	logic [63:0]        st_wdata;
	logic [TW_AW-1:0]   st_raddr;
	logic [63:0]        st_rdata;

	logic               kt_we;
	logic [63:0]        kt_rdata;
	logic [PIDX_W-1:0]  kt_raddr;

	logic               keys_ready;
	logic               in_acc;
	logic               adv;
	logic               hit;
	kind_t              in_kind;
	logic               in_color;
	logic [2:0]         in_type;
	logic [5:0]         in_square;

	logic               v_s1;
	kind_t              kind_s1;
	logic               hit_s1;
	logic [3:0]         castle_s1;
	logic               epv_s1;
	logic [2:0]         epf_s1;
	logic               black_s1;

	logic [63:0]        acc_q;
	logic               out_valid_q;
	logic [63:0]        out_data_q;
	logic [63:0]        hash_val;

	// generator state and key table
	zph_ram #(.WIDTH(64), .DEPTH(TW_N)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (1'b1),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	zph_ram #(.WIDTH(64), .DEPTH(PIECE_KEYS)) u_key_ram (
		.clk   (clk),
		.we    (kt_we),
		.waddr (fc_q[PIDX_W-1:0]),
		.wdata (key_val),
		.re    (in_acc),
		.raddr (kt_raddr),
		.rdata (kt_rdata)
	);

	// fill datapath
	always_comb begin
		t_mix = p_q ^ (p_q >> 62);
		mul_a = t_mix[31:0];
		mul_b = SEED_MULT[31:0];
		if (fsm_q == F_M1) begin
			mul_b = SEED_MULT[63:32];
		end else if (fsm_q == F_M2) begin
			mul_a = t_mix[63:32];
		end
		mul_p    = 64'(mul_a) * 64'(mul_b);
		seed_val = lo_q + {cr1_q + cr2_q, 32'd0} + 64'(si_q);

		ti_next = (ti_q == TW_AW'(TW_N - 1)) ? '0 : ti_q + 1'b1;
		ti_mid  = (ti_q >= TW_AW'(TW_N - TW_M)) ? ti_q - TW_AW'(TW_N - TW_M)
		                                         : ti_q + TW_AW'(TW_M);
		y_mix     = (a_q & TW_UPPER) | (b_q & TW_LOWER);
		twist_val = st_rdata ^ (y_mix >> 1) ^ (y_mix[0] ? TW_MATRIX : 64'd0);
		key_val   = temper(x_q);
		fc_off    = fc_q - FC_W'(PIECE_KEYS);
		fc_off2   = fc_off - FC_W'(EP_KEYS);

		st_we    = 1'b0;
		st_waddr = si_q;
		st_wdata = seed_val;
		st_raddr = ti_q;
		case (fsm_q)
			F_SEED0: begin
				st_we    = 1'b1;
				st_waddr = '0;
				st_wdata = seed_q;
			end
			F_SWR: begin
				st_we = 1'b1;
			end
			F_RDB: begin
				st_raddr = ti_next;
			end
			F_RDC: begin
				st_raddr = ti_mid;
			end
			F_TWIST: begin
				st_we    = 1'b1;
				st_waddr = ti_q;
				st_wdata = twist_val;
			end
			default: begin
			end
		endcase
		kt_we = (fsm_q == F_STORE) && (fc_q < FC_W'(PIECE_KEYS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q  <= F_SEED0;
			seed_q <= SEED_RST;
		end else if (cfg_valid) begin
			fsm_q  <= F_SEED0;
			seed_q <= cfg_data;
		end else begin
			case (fsm_q)
				F_SEED0: fsm_q <= F_M0;
				F_M0:    fsm_q <= F_M1;
				F_M1:    fsm_q <= F_M2;
				F_M2:    fsm_q <= F_SWR;
				F_SWR:   fsm_q <= (si_q == TW_AW'(TW_N - 1)) ? F_RDA : F_M0;
				F_RDA:   fsm_q <= F_RDB;
				F_RDB:   fsm_q <= F_RDC;
				F_RDC:   fsm_q <= F_TWIST;
				F_TWIST: fsm_q <= F_STORE;
				F_STORE: fsm_q <= (fc_q == FC_W'(KEY_COUNT - 1)) ? F_DONE : F_RDA;
				F_DONE:  fsm_q <= F_DONE;
				default: fsm_q <= F_SEED0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (fsm_q)
			F_SEED0: begin
				p_q  <= seed_q;
				si_q <= TW_AW'(1);
			end
			F_M0: lo_q  <= mul_p;
			F_M1: cr1_q <= mul_p[31:0];
			F_M2: cr2_q <= mul_p[31:0];
			F_SWR: begin
				p_q  <= seed_val;
				si_q <= si_q + 1'b1;
				ti_q <= '0;
				fc_q <= '0;
			end
			F_RDB: a_q <= st_rdata;
			F_RDC: b_q <= st_rdata;
			F_TWIST: x_q <= twist_val;
			F_STORE: begin
				if (fc_q >= FC_W'(PIECE_KEYS)) begin
					if (fc_off < FC_W'(EP_KEYS)) begin
						ep_key_q[fc_off[2:0]] <= key_val;
					end else if (fc_off2 < FC_W'(CASTLE_KEYS)) begin
						castle_key_q[fc_off2[3:0]] <= key_val;
					end else begin
						side_key_q <= key_val;
					end
				end
				fc_q <= fc_q + 1'b1;
				ti_q <= ti_next;
			end
			default: begin
			end
		endcase
	end

	// hashing pipeline
	assign keys_ready    = (fsm_q == F_DONE);
	assign cfg_ready     = 1'b1;
	assign adv           = !(v_s1 && kind_s1 == KIND_FINISH) || !out_valid_q || m_axis_tready;
	assign s_axis_tready = keys_ready && (!v_s1 || adv);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		in_kind   = kind_t'(s_axis_tuser);
		in_color  = s_axis_tdata[0];
		in_type   = s_axis_tdata[3:1];
		in_square = s_axis_tdata[9:4];
		hit = (in_kind == KIND_PIECE) && (in_type != 3'd0)
		   && (int'(in_type) < PIECE_KINDS) && (int'(in_square) < SQUARES);
		kt_raddr = PIDX_W'((int'(in_color) * PIECE_KINDS + int'(in_type)) * SQUARES
		                   + int'(in_square));
		hash_val = acc_q ^ castle_key_q[castle_s1]
		         ^ (epv_s1 ? ep_key_q[epf_s1] : 64'd0)
		         ^ (black_s1 ? side_key_q : 64'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			if (adv && v_s1 && kind_s1 == KIND_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				v_s1 <= in_acc;
				if (v_s1) begin
					case (kind_s1)
						KIND_START:  acc_q <= '0;
						KIND_PIECE: begin
							if (hit_s1) begin
								acc_q <= acc_q ^ kt_rdata;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1   <= in_kind;
			hit_s1    <= hit;
			castle_s1 <= s_axis_tdata[13:10];
			epv_s1    <= s_axis_tdata[14];
			epf_s1    <= s_axis_tdata[17:15];
			black_s1  <= s_axis_tdata[18];
			if (v_s1 && kind_s1 == KIND_FINISH) begin
				out_data_q <= hash_val;
			end
		end
	end

endmodule

// File: test/zobrist_position_hash_top_tb.sv
// ----------------------------------------------------------------------------
// zobrist_position_hash_top_tb
// self-checking testbench of the zobrist position hash block
// ----------------------------------------------------------------------------
// Builds its own mt19937-64 key table for every seed and tracks the hash
// accumulator. Each accepted item updates that model and each finish queues
// an expected hash. Every output item is checked against the oldest queued
// hash. Stimulus is a directed part followed by random positions and noise,
// run under several seeds, with random stalls on both stream sides.
module zobrist_position_hash_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import zph_pkg::*;

	localparam int SQ = 64;
	localparam int PK = 7;
	localparam int EP_AT = 2 * PK * SQ;
	localparam int CASTLE_AT = EP_AT + 8;
	localparam int SIDE_AT = CASTLE_AT + 16;
	localparam int NKEYS = SIDE_AT + 1;
	localparam int STALL_LIMIT = 40000;

	class hash_scoreboard;
		logic [63:0] keys [NKEYS];
		logic [63:0] mt [TW_N];
		int mt_pos;
		logic [63:0] acc = '0;
		logic [63:0] want_q [$];
		int errors;

		function void mt_regen();
			logic [63:0] y, v;
			for (int i = 0; i < TW_N; i++) begin
				y = (mt[i] & 64'hFFFF_FFFF_8000_0000) | (mt[(i + 1) % TW_N] & 64'h7FFF_FFFF);
				v = mt[(i + TW_M) % TW_N] ^ (y >> 1);
				if (y[0]) v = v ^ 64'hB502_6F5A_A966_19E9;
				mt[i] = v;
			end
			mt_pos = 0;
		endfunction

		function logic [63:0] mt_next();
			logic [63:0] x;
			if (mt_pos >= TW_N) mt_regen();
			x = mt[mt_pos];
			mt_pos++;
			x ^= (x >> 29) & 64'h5555_5555_5555_5555;
			x ^= (x << 17) & 64'h71D6_7FFF_EDA6_0000;
			x ^= (x << 37) & 64'hFFF7_EEE0_0000_0000;
			x ^= x >> 43;
			return x;
		endfunction

		function void reseed(logic [63:0] seed);
			logic [63:0] p;
			mt[0] = seed;
			for (int i = 1; i < TW_N; i++) begin
				p = mt[i - 1];
				mt[i] = 64'd6364136223846793005 * (p ^ (p >> 62)) + 64'(i);
			end
			mt_pos = TW_N;
			for (int k = 0; k < NKEYS; k++) keys[k] = mt_next();
		endfunction

		function void note_item(kind_t kind, logic [23:0] d);
			logic [63:0] h;
			int idx;
			case (kind)
				KIND_START: acc = '0;
				KIND_PIECE: begin
					if (d[3:1] != 0 && d[3:1] < PK) begin
						idx = (int'(d[0]) * PK + int'(d[3:1])) * SQ + int'(d[9:4]);
						acc ^= keys[idx];
					end
				end
				KIND_FINISH: begin
					h = acc ^ keys[CASTLE_AT + int'(d[13:10])];
					if (d[14]) h ^= keys[EP_AT + int'(d[17:15])];
					if (d[18]) h ^= keys[SIDE_AT];
					want_q.push_back(h);
				end
				default: ;
			endcase
		endfunction

		function void check_hash(logic [63:0] got);
			logic [63:0] w;
			if (want_q.size() == 0) begin
				$display("%0t: unexpected hash, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			w = want_q.pop_front();
			if (w !== got) begin
				$display("%0t: hash mismatch, expected %h, actual %h", $time, w, got);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [63:0] cfg_data = '0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [63:0] m_axis_tdata;

	hash_scoreboard sb = new();
	bit quiet = 0;
	int stall_cnt = 0;

	zobrist_position_hash_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
		if (m_axis_tvalid && m_axis_tready) sb.check_hash(m_axis_tdata);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
		    (cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("zobrist_position_hash_top test failed");
				$finish;
			end
		end
	end

	function automatic logic [23:0] pack(logic color, logic [2:0] ptype, logic [5:0] sq,
		logic [3:0] castle, logic epv, logic [2:0] epf, logic black);
		return {5'b0, black, epf, epv, castle, sq, ptype, color};
	endfunction

	task automatic send(kind_t kind, logic [23:0] d);
		int gap;
		gap = 0;
		if (!quiet) while ($urandom_range(99) < 18) gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= kind;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_item(kind, d);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_seed(logic [63:0] seed);
		drain();
		cfg_valid <= 1;
		cfg_data <= seed;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		sb.reseed(seed);
	endtask

	task automatic random_finish();
		send(KIND_FINISH, pack(1'($urandom), 3'($urandom), 6'($urandom), 4'($urandom),
			1'($urandom), 3'($urandom), 1'($urandom)));
	endtask

	task automatic random_position();
		int n;
		logic [2:0] t;
		send(KIND_START, 24'($urandom));
		n = $urandom_range(1, 20);
		repeat (n) begin
			t = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 6));
			send(KIND_PIECE, pack(1'($urandom), t, 6'($urandom), 4'($urandom),
				1'($urandom), 3'($urandom), 1'($urandom)));
		end
		random_finish();
	endtask

	task automatic random_phase(int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(99) < 80) begin
				random_position();
				sent += 12;
			end else begin
				send(kind_t'($urandom_range(3)), 24'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		sb.reseed(SEED_RST);
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// a piece before any start, then extremes and special cases
		send(KIND_PIECE, pack(0, 1, 0, 0, 0, 0, 0));
		send(KIND_FINISH, pack(0, 0, 0, 0, 0, 0, 0));
		send(KIND_START, '0);
		send(KIND_PIECE, pack(1, 6, 63, 0, 0, 0, 0));
		send(KIND_PIECE, pack(0, 0, 12, 0, 0, 0, 0));
		send(KIND_PIECE, pack(1, 7, 40, 0, 0, 0, 0));
		send(KIND_PIECE, pack(0, 3, 27, 15, 1, 7, 1));
		send(KIND_NONE, 24'hFFFFFF);
		send(KIND_FINISH, pack(0, 0, 0, 15, 1, 7, 1));
		send(KIND_FINISH, pack(0, 0, 0, 15, 1, 7, 1));
		send(KIND_FINISH, pack(1, 7, 63, 5, 1, 0, 0));
		send(KIND_FINISH, pack(0, 0, 0, 10, 0, 3, 1));
		send(KIND_START, 24'hFFFFFF);
		send(KIND_FINISH, pack(0, 0, 0, 0, 0, 0, 0));

		quiet = 1;
		random_phase(40);
		quiet = 0;
		random_phase(40);
		write_seed(64'd0);
		random_phase(70);
		write_seed(64'hFFFF_FFFF_FFFF_FFFF);
		random_phase(70);
		write_seed({$urandom, $urandom});
		random_phase(70);
		write_seed(SEED_RST);
		random_phase(70);
		drain();
		if (sb.errors == 0) begin
			$display("zobrist_position_hash_top test passed");
		end else begin
			$display("zobrist_position_hash_top test failed");
		end
		$finish;
	end
endmodule

// File: zobrist_position_hash_top.f
design/zph_pkg.sv
design/zph_ram.sv
design/zobrist_position_hash_top.sv
test/zobrist_position_hash_top_tb.sv
